>>> hw/rtl/ttbc_pkg.sv
package ttbc_pkg;

   // Nesting capacity of the kind stack
   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
   localparam int KIND_W      = 2;

   // Character codes
   localparam logic [7:0] CHAR_CURLY_OPEN   = 8'h7B;  // {
   localparam logic [7:0] CHAR_ROUND_OPEN   = 8'h28;  // (
   localparam logic [7:0] CHAR_SQUARE_OPEN  = 8'h5B;  // [
   localparam logic [7:0] CHAR_CURLY_CLOSE  = 8'h7D;  // }
   localparam logic [7:0] CHAR_ROUND_CLOSE  = 8'h29;  // )
   localparam logic [7:0] CHAR_SQUARE_CLOSE = 8'h5D;  // ]

   typedef enum logic [KIND_W-1:0] {
      KIND_NONE   = 2'd0,
      KIND_CURLY  = 2'd1,
      KIND_ROUND  = 2'd2,
      KIND_SQUARE = 2'd3
   } kind_type;

   // Result of one string, overflow above balanced
   typedef struct packed {
      logic overflow;
      logic balanced;
   } result_type;

   function automatic kind_type opener_kind(input logic [7:0] c);
      kind_type k;
      unique case (c)
         CHAR_CURLY_OPEN:  k = KIND_CURLY;
         CHAR_ROUND_OPEN:  k = KIND_ROUND;
         CHAR_SQUARE_OPEN: k = KIND_SQUARE;
         default:          k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic kind_type closer_kind(input logic [7:0] c);
      kind_type k;
      unique case (c)
         CHAR_CURLY_CLOSE:  k = KIND_CURLY;
         CHAR_ROUND_CLOSE:  k = KIND_ROUND;
         CHAR_SQUARE_CLOSE: k = KIND_SQUARE;
         default:           k = KIND_NONE;
      endcase
      return k;
   endfunction

endpackage

>>> hw/rtl/ttbc_stack_ram.sv
module ttbc_stack_ram #(
   parameter int DEPTH  = 64,
   parameter int DATA_W = 2,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   // One write port, one registered read port (old data on collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> hw/rtl/ttbc_ctrl.sv
module ttbc_ctrl
   import ttbc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               item_accept,
   input  logic [7:0]         char_code,
   input  logic               last,
   output logic               result_valid,
   output result_type         result,
   output logic               ram_wr_en,
   output logic [ADDR_W-1:0]  ram_wr_addr,
   output logic [KIND_W-1:0]  ram_wr_data,
   output logic [ADDR_W-1:0]  ram_rd_addr,
   input  logic [KIND_W-1:0]  ram_rd_data
);

   // Top of stack lives here; entries below it live in the RAM
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               mis_ff, mis_in;
   logic               ovf_ff, ovf_in;
   kind_type           tos_ff, tos_in;
   logic               byp_ff, byp_in;
   kind_type           byp_data_ff, byp_data_in;

   kind_type           open_k;
   kind_type           close_k;
   kind_type           below;
   logic [DEPTH_W-1:0] upd_depth;
   logic               upd_mis;
   logic               upd_ovf;

   assign open_k  = opener_kind(char_code);
   assign close_k = closer_kind(char_code);

   // Second entry from the top: forwarded when last cycle wrote it
   assign below = byp_ff ? byp_data_ff : kind_type'(ram_rd_data);

   // Push / pop decision for one character
   always_comb begin
      upd_depth   = depth_ff;
      upd_mis     = mis_ff;
      upd_ovf     = ovf_ff;
      tos_in      = tos_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = ADDR_W'(depth_ff - DEPTH_W'(1));
      ram_wr_data = tos_ff;
      if (item_accept && !mis_ff && !ovf_ff) begin
         if (open_k != KIND_NONE) begin
            if (depth_ff == DEPTH_W'(STACK_DEPTH)) begin
               upd_ovf = 1'b1;
            end else begin
               tos_in    = open_k;
               upd_depth = depth_ff + DEPTH_W'(1);
               ram_wr_en = (depth_ff != '0);
            end
         end else if (close_k != KIND_NONE) begin
            if (depth_ff == '0 || tos_ff != close_k) begin
               upd_mis = 1'b1;
            end else begin
               tos_in    = below;
               upd_depth = depth_ff - DEPTH_W'(1);
            end
         end
      end
   end

   // Result on the final character, then clear for the next string
   always_comb begin
      result_valid    = item_accept && last;
      result.balanced = !upd_mis && !upd_ovf && (upd_depth == '0);
      result.overflow = upd_ovf;
      if (result_valid) begin
         depth_in = '0;
         mis_in   = 1'b0;
         ovf_in   = 1'b0;
      end else begin
         depth_in = upd_depth;
         mis_in   = upd_mis;
         ovf_in   = upd_ovf;
      end
   end

   // Prefetch the entry that becomes top after a pop next cycle
   always_comb begin
      ram_rd_addr = ADDR_W'(depth_in - DEPTH_W'(2));
      byp_in      = ram_wr_en && (ram_wr_addr == ram_rd_addr);
      byp_data_in = kind_type'(ram_wr_data);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         mis_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
         byp_ff   <= 1'b0;
      end else begin
         depth_ff <= depth_in;
         mis_ff   <= mis_in;
         ovf_ff   <= ovf_in;
         byp_ff   <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff      <= tos_in;
      byp_data_ff <= byp_data_in;
   end

endmodule

>>> hw/rtl/three_type_bracket_checker_top.sv
// Bracket checker for curly, round and square brackets. Feed one character
// per transaction on req_ with req_tlast on the final character; one result
// transaction comes out per string, registered, in the cycle after its final
// character is taken. A character is taken every cycle: the top of the
// 64-entry kind stack sits in a register and the entries below it in a small
// RAM whose next-below entry is prefetched each cycle, with forwarding when a
// push just wrote it. A result held in the output register while rsp_tready
// is low holds req_tready low until that result is taken. Nesting deeper than
// 64 sets overflow and fails the string. No clearing pass runs after reset.
module three_type_bracket_checker_top
   import ttbc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tlast,   // last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] balanced, [1] overflow, [7:2] zero
);

   logic              accept;
   logic              result_valid;
   result_type        result;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [KIND_W-1:0] ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [KIND_W-1:0] ram_rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff, rsp_data_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   ttbc_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .item_accept  (accept),
      .char_code    (req_tdata),
      .last         (req_tlast),
      .result_valid (result_valid),
      .result       (result),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data)
   );

   ttbc_stack_ram #(
      .DEPTH  (STACK_DEPTH),
      .DATA_W (KIND_W),
      .ADDR_W (ADDR_W)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (result_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_data_ff.overflow, rsp_data_ff.balanced};

endmodule
